[rtl/scg_pkg.sv]
package scg_pkg;

	// Action codes (input tuser bits [1:0])
	localparam logic [1:0] ACT_SAMPLE   = 2'd0;
	localparam logic [1:0] ACT_VELOCITY = 2'd1;
	localparam logic [1:0] ACT_TICK     = 2'd2;

	// Sensor select codes (input tuser bits [3:2])
	localparam logic [1:0] SEL_NONE  = 2'd0;
	localparam logic [1:0] SEL_LEFT  = 2'd1;
	localparam logic [1:0] SEL_RIGHT = 2'd2;
	localparam logic [1:0] SEL_FRONT = 2'd3;

	// Motor command codes
	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_ENABLE  = 2'd1;
	localparam logic [1:0] CMD_DISABLE = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_NEAR   = 3'd0;
	localparam logic [2:0] REG_FAR    = 3'd1;
	localparam logic [2:0] REG_WEIGHT = 3'd2;
	localparam logic [2:0] REG_MASK   = 3'd3;
	localparam logic [2:0] REG_REVEX  = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Reset register values
	localparam logic [15:0] NEAR_RESET   = 16'd819;
	localparam logic [15:0] FAR_RESET    = 16'd1024;
	localparam logic [8:0]  WEIGHT_RESET = 9'd154;
	localparam logic [2:0]  MASK_RESET   = 3'd7;
	localparam logic        REVEX_RESET  = 1'b1;

	localparam int RANGE_BITS_DEF = 16;
	localparam int AVG_RESET      = 2048;  // twice the reset far threshold

	// Side limit arithmetic: 1.4 = 358/256, 0.10 m = 410, 0.05 m = 205
	localparam int          LIM_W     = 17;
	localparam logic [24:0] SIDE_MUL  = 25'd358;
	localparam logic [LIM_W-1:0] LEFT_ADD  = 17'd410;
	localparam logic [LIM_W-1:0] RIGHT_SUB = 17'd205;

	// Hit bit positions
	localparam int HIT_LEFT  = 0;
	localparam int HIT_FRONT = 1;
	localparam int HIT_RIGHT = 2;

	typedef struct packed {
		logic [LIM_W-1:0] front;
		logic [LIM_W-1:0] left;
		logic [LIM_W-1:0] right;
	} limits_t;

	typedef struct packed {
		limits_t    near_lim;
		limits_t    far_lim;
		logic [8:0] weight;    // already clamped to 256
		logic [2:0] mask;
		logic       rev_exit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [1:0]  sensor_select;
		logic [15:0] sample_range;
		logic        reverse_motion;
	} item_t;

	typedef struct packed {
		logic [1:0] motor_command;
		logic [2:0] near_hits;
		logic       stopped_flag;
	} result_t;

	function automatic limits_t make_limits(input logic [15:0] t);
		logic [24:0]      prod;
		logic [LIM_W-1:0] scaled;
		limits_t          lim;
		prod       = 25'(t) * SIDE_MUL;
		scaled     = prod[24:8];
		lim.front  = LIM_W'(t);
		lim.left   = scaled + LEFT_ADD;
		lim.right  = (scaled > RIGHT_SUB) ? (scaled - RIGHT_SUB) : '0;
		return lim;
	endfunction

endpackage

[rtl/scg_cfg_regs.sv]
module scg_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [scg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output scg_pkg::cfg_t                     cfg
);
	import scg_pkg::*;

	cfg_t cfg_q;

	// limits are precomputed at write time so the tick path only compares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_lim <= make_limits(NEAR_RESET);
			cfg_q.far_lim  <= make_limits(FAR_RESET);
			cfg_q.weight   <= WEIGHT_RESET;
			cfg_q.mask     <= MASK_RESET;
			cfg_q.rev_exit <= REVEX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEAR:   cfg_q.near_lim <= make_limits(cfg_wdata);
				REG_FAR:    cfg_q.far_lim  <= make_limits(cfg_wdata);
				REG_WEIGHT: cfg_q.weight   <= (cfg_wdata[8:0] > 9'd256) ? 9'd256
					: cfg_wdata[8:0];
				REG_MASK:   cfg_q.mask     <= cfg_wdata[2:0];
				REG_REVEX:  cfg_q.rev_exit <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/scg_core.sv]
module scg_core #(
	parameter int RANGE_BITS = scg_pkg::RANGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scg_pkg::cfg_t     cfg,
	input  scg_pkg::item_t    item,
	input  logic              fire,
	output scg_pkg::result_t  result
);
	import scg_pkg::*;

	localparam int CMP_W = (RANGE_BITS > LIM_W) ? RANGE_BITS : LIM_W;
	localparam logic [RANGE_BITS-1:0] AVG_START =
		(RANGE_BITS >= 12) ? RANGE_BITS'(AVG_RESET) : {RANGE_BITS{1'b1}};

	logic [RANGE_BITS-1:0] avg_q [3];
	logic                  back_q;
	logic                  held_q;

	logic [1:0]                   slot;
	logic                         slot_ok;
	logic [RANGE_BITS-1:0]        r;
	logic [RANGE_BITS-1:0]        old;
	logic signed [RANGE_BITS:0]   diff;
	logic signed [9:0]            w_s;
	logic signed [RANGE_BITS+10:0] prod;
	logic signed [RANGE_BITS+2:0] step;
	logic signed [RANGE_BITS+2:0] sum;
	logic [RANGE_BITS-1:0]        avg_new;
	logic [2:0]                   hits_near;
	logic [2:0]                   hits_far;
	logic                         rev;
	logic                         held_d;
	logic [1:0]                   cmd;

	always_comb begin
		slot    = 2'd0;
		slot_ok = 1'b1;
		unique case (item.sensor_select)
			SEL_LEFT:  slot = 2'd0;
			SEL_FRONT: slot = 2'd1;
			SEL_RIGHT: slot = 2'd2;
			default:   slot_ok = 1'b0;
		endcase
	end

	// new = old + floor((r - old) * w / 256), same as the two-term blend
	assign r       = RANGE_BITS'(item.sample_range);
	assign old     = avg_q[slot];
	assign diff    = $signed({1'b0, r}) - $signed({1'b0, old});
	assign w_s     = $signed({1'b0, cfg.weight});
	assign prod    = diff * w_s;
	assign step    = $signed(prod[RANGE_BITS+10:8]);
	assign sum     = step + $signed({3'b000, old});
	assign avg_new = sum[RANGE_BITS-1:0];

	function automatic logic [2:0] check(input limits_t lim, input logic [2:0] mask,
		input logic [RANGE_BITS-1:0] a_l, input logic [RANGE_BITS-1:0] a_f,
		input logic [RANGE_BITS-1:0] a_r);
		logic [2:0] h;
		h[HIT_LEFT]  = mask[HIT_LEFT]  && (CMP_W'(a_l) <= CMP_W'(lim.left));
		h[HIT_FRONT] = mask[HIT_FRONT] && (CMP_W'(a_f) <= CMP_W'(lim.front));
		h[HIT_RIGHT] = mask[HIT_RIGHT] && (CMP_W'(a_r) <= CMP_W'(lim.right));
		return h;
	endfunction

	assign hits_near = check(cfg.near_lim, cfg.mask, avg_q[0], avg_q[1], avg_q[2]);
	assign hits_far  = check(cfg.far_lim,  cfg.mask, avg_q[0], avg_q[1], avg_q[2]);
	assign rev       = cfg.rev_exit && back_q;

	always_comb begin
		held_d = held_q;
		cmd    = CMD_NONE;
		if (hits_near != 3'b000) begin
			if (rev) begin
				if (held_q) cmd = CMD_ENABLE;
				held_d = 1'b0;
			end else if (!held_q) begin
				held_d = 1'b1;
				cmd    = CMD_DISABLE;
			end
		end else if ((hits_far == 3'b000) || rev) begin
			if (held_q) begin
				held_d = 1'b0;
				cmd    = CMD_ENABLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q[0] <= AVG_START;
			avg_q[1] <= AVG_START;
			avg_q[2] <= AVG_START;
			back_q   <= 1'b0;
			held_q   <= 1'b0;
		end else if (fire) begin
			case (item.action)
				ACT_SAMPLE:   if (slot_ok) avg_q[slot] <= avg_new;
				ACT_VELOCITY: back_q <= item.reverse_motion;
				ACT_TICK:     held_q <= held_d;
				default: ;
			endcase
		end
	end

	assign result.motor_command = cmd;
	assign result.near_hits     = hits_near;
	assign result.stopped_flag  = held_d;

	wire is_tick = fire && (item.action == ACT_TICK);

	a_disable_sets_hold: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick && (cmd == CMD_DISABLE) |=> held_q)
		else $error("disable command without hold");

	a_enable_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick && (cmd == CMD_ENABLE) |=> !held_q)
		else $error("enable command while hold stays");

	a_hold_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!is_tick |=> $stable(held_q))
		else $error("hold changed outside a tick");

	a_cmd_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick && (cmd == CMD_NONE) |=> (held_q == $past(held_q)))
		else $error("hold changed with no command");

endmodule

[rtl/sonar_collision_guard_unit.sv]
// Sonar collision guard. Slave words carry sonar samples, velocity updates
// and evaluation ticks; each tick yields one master word with the motor
// command, the near-hit mask and the hold flag, other actions yield nothing.
// A word is taken every cycle while s_tready is high: it lands in an input
// register, is resolved by one combinational pass (one blend multiply for
// samples, threshold compares for ticks) and leaves through an output
// register. m_tvalid rises once a tick has moved from the input register
// into the output register; throughput is one word per cycle unless stalled.
// s_tready drops only when a tick sits in the input register while
// the output register holds an untaken result. Side limits are derived from
// the thresholds when they are written. Configuration writes take effect on
// the next edge and should only be issued while no words are in flight.
module sonar_collision_guard_unit #(
	parameter int RANGE_BITS = scg_pkg::RANGE_BITS_DEF  // 10..24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,   // [15:0] sample_range, [16] reverse_motion
	input  logic [3:0]                      s_tuser,   // [1:0] action, [3:2] sensor_select
	// master side
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [1:0] motor_command, [4:2] near_hits,
	                                                   // [5] stopped_flag
	// configuration
	input  logic                            cfg_we,
	input  logic [scg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [scg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import scg_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    has_res;
	logic    adv;
	logic    fire;

	scg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// only ticks need room in the output register
	assign has_res  = (item_s1.action == ACT_TICK);
	assign adv      = !has_res || !out_valid_q || m_tready;
	assign fire     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.action         <= s_tuser[1:0];
			item_s1.sensor_select  <= s_tuser[3:2];
			item_s1.sample_range   <= s_tdata[15:0];
			item_s1.reverse_motion <= s_tdata[16];
		end
	end

	scg_core #(
		.RANGE_BITS (RANGE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (fire),
		.result (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && has_res) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.stopped_flag, res_q.near_hits, res_q.motor_command};

	a_hold_stalled_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("stalled input word lost");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> out_valid_q && !m_tready && valid_s1)
		else $error("input stalled without a pending result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fire && has_res |=> m_tvalid)
		else $error("tick result not presented");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

// Self-checking bench for the sonar collision guard.
// A directed table runs first (reset behavior, ignored words, hold entry,
// reverse release, hysteresis), then eight random phases, each with its own
// register setting and one of four idle patterns. Every accepted tick goes
// through the guard model below; results are matched in order to its queue.
module tb_top;
	import scg_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;   // action code the block ignores
	localparam int N_PHASES        = 8;
	localparam int WORDS_PER_PHASE = 200;
	localparam int SETTLE_CYCLES   = 4;         // two-stage pipe plus margin
	localparam int CYCLE_LIMIT     = 200000;

	typedef struct {
		item_t   word;
		bit      typed;   // expected result typed into the row
		result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;    // [15:0] sample_range, [16] reverse_motion
	logic [3:0]  s_tuser;    // [1:0] action, [3:2] sensor_select
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // [1:0] motor_command, [4:2] near_hits, [5] stopped_flag
	logic        cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	sonar_collision_guard_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// ---------------------------------------------------------------------
	// Guard model state: register copies, averages, motion and hold flags
	// ---------------------------------------------------------------------
	logic [15:0] near_t;
	logic [15:0] far_t;
	logic [8:0]  wt;
	logic [2:0]  en_mask;
	logic        rev_ok;
	logic [15:0] avg_est [0:2];   // indexed by hit bit: left, front, right
	bit          backing;
	bit          held;

	result_t     pending_results [$];
	stim_row_t   dir_rows [$];
	int          err_count;
	int          cycle_count;
	int unsigned gap_pct;        // sender idle chance per cycle, percent
	int unsigned stall_pct;      // receiver stall chance per cycle, percent

	// near mask for threshold t: front uses t, sides use 1.4*t +0.10 / -0.05 m
	function automatic logic [2:0] hits_within(input logic [15:0] t);
		int unsigned scaled;
		int unsigned lim_l;
		int unsigned lim_r;
		logic [2:0]  h;
		scaled = (32'(t) * 32'(SIDE_MUL)) >> 8;
		lim_l  = scaled + 32'(LEFT_ADD);
		lim_r  = (scaled > 32'(RIGHT_SUB)) ? scaled - 32'(RIGHT_SUB) : 0;
		h = '0;
		if (en_mask[HIT_FRONT] && avg_est[HIT_FRONT] <= t)
			h[HIT_FRONT] = 1'b1;
		if (en_mask[HIT_LEFT] && 32'(avg_est[HIT_LEFT]) <= lim_l)
			h[HIT_LEFT] = 1'b1;
		if (en_mask[HIT_RIGHT] && 32'(avg_est[HIT_RIGHT]) <= lim_r)
			h[HIT_RIGHT] = 1'b1;
		return h;
	endfunction

	// advance the model by one accepted word; returns 1 when a result is due
	function automatic bit guard_predict(input item_t w, output result_t r);
		logic [8:0]  wt_eff;
		int          slot;
		int unsigned mix;
		logic [2:0]  near_h;
		bit          rev_now;
		r = '0;
		r.motor_command = CMD_NONE;
		case (w.action)
			ACT_SAMPLE: begin
				wt_eff = (wt > 9'd256) ? 9'd256 : wt;
				case (w.sensor_select)
					SEL_LEFT:  slot = HIT_LEFT;
					SEL_FRONT: slot = HIT_FRONT;
					SEL_RIGHT: slot = HIT_RIGHT;
					default:   slot = -1;
				endcase
				if (slot >= 0) begin
					mix = 32'(w.sample_range) * 32'(wt_eff)
						+ 32'(avg_est[slot]) * (32'd256 - 32'(wt_eff));
					avg_est[slot] = 16'(mix >> 8);
				end
				return 1'b0;
			end
			ACT_VELOCITY: begin
				backing = w.reverse_motion;
				return 1'b0;
			end
			ACT_TICK: begin
				rev_now = rev_ok && backing;
				near_h  = hits_within(near_t);
				if (near_h != 3'd0) begin
					if (rev_now) begin
						if (held)
							r.motor_command = CMD_ENABLE;
						held = 1'b0;
					end else if (!held) begin
						held = 1'b1;
						r.motor_command = CMD_DISABLE;
					end
				end else if (hits_within(far_t) == 3'd0 || rev_now) begin
					// hysteresis: release once clear of the far limits, or while reversing
					if (held) begin
						held = 1'b0;
						r.motor_command = CMD_ENABLE;
					end
				end
				r.near_hits    = near_h;
				r.stopped_flag = held;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit is_ignored(input item_t w);
		return (w.action == ACT_UNUSED)
			|| (w.action == ACT_SAMPLE && w.sensor_select == SEL_NONE);
	endfunction

	function automatic void add_row(input logic [1:0] act, input logic [1:0] sel,
			input logic [15:0] meas, input logic rev, input bit typed,
			input logic [1:0] cmd, input logic [2:0] hits, input logic stop);
		stim_row_t r;
		r.word.action         = act;
		r.word.sensor_select  = sel;
		r.word.sample_range   = meas;
		r.word.reverse_motion = rev;
		r.typed               = typed;
		r.want.motor_command  = cmd;
		r.want.near_hits      = hits;
		r.want.stopped_flag   = stop;
		dir_rows.push_back(r);
	endfunction

	// random word: mostly samples and ticks with ranges around the limits
	function automatic stim_row_t random_row();
		stim_row_t   r;
		int unsigned pick;
		int unsigned span;
		pick = $urandom_range(99);
		span = 2 * ((near_t > far_t) ? near_t : far_t) + 600;
		if (span > 65535)
			span = 65535;
		r.typed = 1'b0;
		r.want  = '0;
		r.word.sample_range   = ($urandom_range(4) == 0) ? 16'($urandom)
			: 16'($urandom_range(span));
		r.word.reverse_motion = 1'($urandom);
		case ($urandom_range(2))
			0:       r.word.sensor_select = SEL_LEFT;
			1:       r.word.sensor_select = SEL_RIGHT;
			default: r.word.sensor_select = SEL_FRONT;
		endcase
		if (pick < 58) begin
			r.word.action = ACT_SAMPLE;
		end else if (pick < 70) begin
			r.word.action         = ACT_VELOCITY;
			r.word.reverse_motion = ($urandom_range(9) < 4);
		end else if (pick < 95) begin
			r.word.action = ACT_TICK;
		end else if (pick < 98) begin
			r.word.action        = ACT_UNUSED;
			r.word.sensor_select = 2'($urandom);
		end else begin
			r.word.action        = ACT_SAMPLE;
			r.word.sensor_select = SEL_NONE;
		end
		return r;
	endfunction

	// Called in the step of a rising edge; returns in the step of the edge that
	// took the word. s_tvalid is left high so a following word does not bounce it.
	task automatic send_word(input stim_row_t row);
		bit      rdy;
		bit      due;
		result_t res;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, row.word.reverse_motion, row.word.sample_range};
		s_tuser  <= {row.word.sensor_select, row.word.action};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		due = guard_predict(row.word, res);
		if (due)
			pending_results.push_back(row.typed ? row.want : res);
	endtask

	// stop sending and let the pipe drain; the extra cycles cover words
	// that make no result but may still be in flight
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_NEAR:   near_t  = data;
			REG_FAR:    far_t   = data;
			REG_WEIGHT: wt      = data[8:0];
			REG_MASK:   en_mask = data[2:0];
			REG_REVEX:  rev_ok  = data[0];
			default: ;
		endcase
	endtask

	// junk in the bits above each register's width must be dropped
	task automatic apply_settings(input logic [15:0] nr, input logic [15:0] fr,
			input logic [8:0] w9, input logic [2:0] m3, input logic r1);
		write_reg(REG_NEAR, nr);
		write_reg(REG_FAR, fr);
		write_reg(REG_WEIGHT, {7'($urandom), w9});
		write_reg(REG_MASK, {13'($urandom), m3});
		write_reg(REG_REVEX, {15'($urandom), r1});
		// index past the register list: no effect
		write_reg(CFG_IDX_W'(REG_REVEX + $urandom_range(1, 3)), 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Clock, cycle limit, receiver
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL sonar_collision_guard_unit");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// Outputs are stable from the falling edge to the next rising edge, so a
	// word seen here with valid and ready high is the one taken at that edge.
	always @(negedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.motor_command = m_tdata[1:0];
			got.near_hits     = m_tdata[4:2];
			got.stopped_flag  = m_tdata[5];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, actual %h", $time, got);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.motor_command !== want.motor_command) begin
					$display("%0t: motor_command expected %0d actual %0d", $time,
						want.motor_command, got.motor_command);
					err_count++;
				end
				if (got.near_hits !== want.near_hits) begin
					$display("%0t: near_hits expected %b actual %b", $time,
						want.near_hits, got.near_hits);
					err_count++;
				end
				if (got.stopped_flag !== want.stopped_flag) begin
					$display("%0t: stopped_flag expected %b actual %b", $time,
						want.stopped_flag, got.stopped_flag);
					err_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------
	initial begin
		stim_row_t row;
		int        counted;
		bit        paused;
		logic [15:0] nr;
		logic [15:0] fr;

		err_count   = 0;
		cycle_count = 0;
		gap_pct     = 0;
		stall_pct   = 0;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= '0;
		m_tready    <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_wdata   <= '0;

		// model starts from the reset values
		near_t  = NEAR_RESET;
		far_t   = FAR_RESET;
		wt      = WEIGHT_RESET;
		en_mask = MASK_RESET;
		rev_ok  = REVEX_RESET;
		for (int i = 0; i < 3; i++)
			avg_est[i] = 16'(AVG_RESET);
		backing = 1'b0;
		held    = 1'b0;

		// Directed table. Typed rows: reset state is clear; one zero sample
		// per sensor brings every average to 816, inside all near limits.
		add_row(ACT_TICK,     SEL_NONE,  16'h0000, 1'b0, 1, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_UNUSED,   SEL_FRONT, 16'hFFFF, 1'b1, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_SAMPLE,   SEL_NONE,  16'hFFFF, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_TICK,     SEL_FRONT, 16'hFFFF, 1'b1, 1, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_SAMPLE,   SEL_LEFT,  16'h0000, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_SAMPLE,   SEL_FRONT, 16'h0000, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_SAMPLE,   SEL_RIGHT, 16'h0000, 1'b1, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_TICK,     SEL_NONE,  16'h0000, 1'b0, 1, CMD_DISABLE, 3'b111, 1'b1);
		add_row(ACT_VELOCITY, SEL_FRONT, 16'hFFFF, 1'b1, 0, CMD_NONE,    3'b000, 1'b0);
		// reverse motion releases the hold even with objects near
		add_row(ACT_TICK,     SEL_NONE,  16'h0000, 1'b0, 1, CMD_ENABLE,  3'b111, 1'b0);
		add_row(ACT_TICK,     SEL_NONE,  16'h0000, 1'b0, 1, CMD_NONE,    3'b111, 1'b0);
		add_row(ACT_VELOCITY, SEL_NONE,  16'h0000, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_TICK,     SEL_NONE,  16'h0000, 1'b0, 1, CMD_DISABLE, 3'b111, 1'b1);
		// far readings: hysteresis decides the release
		add_row(ACT_SAMPLE,   SEL_LEFT,  16'hFFFF, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_SAMPLE,   SEL_FRONT, 16'hFFFF, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_SAMPLE,   SEL_RIGHT, 16'hFFFF, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_TICK,     SEL_NONE,  16'h0000, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_TICK,     SEL_NONE,  16'h0000, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_SAMPLE,   SEL_FRONT, 16'h0000, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_SAMPLE,   SEL_FRONT, 16'h0000, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_TICK,     SEL_NONE,  16'h0000, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_VELOCITY, SEL_RIGHT, 16'h5A5A, 1'b1, 0, CMD_NONE,    3'b000, 1'b0);
		add_row(ACT_TICK,     SEL_NONE,  16'h0000, 1'b0, 0, CMD_NONE,    3'b000, 1'b0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i]);

		for (int p = 0; p < N_PHASES; p++) begin
			drain_pipe();
			case (p)
				0: apply_settings(NEAR_RESET, FAR_RESET, WEIGHT_RESET, MASK_RESET,
					REVEX_RESET);
				1: apply_settings(16'h0000, 16'h0000, 9'd256, 3'd7, 1'b0);
				// oversized weight acts as full weight
				2: apply_settings(16'hFFFF, 16'hFFFF, 9'd511, 3'd5, 1'b1);
				3: apply_settings(16'($urandom_range(300, 3000)),
					16'($urandom_range(300, 5000)), 9'd0, 3'd0, 1'($urandom));
				default: begin
					nr = 16'($urandom_range(200, 4000));
					fr = (p == N_PHASES - 1) ? 16'($urandom_range(100, 6000))
						: 16'(nr + $urandom_range(0, 2000));
					apply_settings(nr, fr, 9'($urandom_range(0, 300)),
						3'($urandom_range(1, 7)), 1'($urandom));
				end
			endcase
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 68; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 68; end
				default: begin gap_pct = 26; stall_pct = 26; end
			endcase
			counted = 0;
			paused  = 1'b0;
			while (counted < WORDS_PER_PHASE) begin
				row = random_row();
				send_word(row);
				if (!is_ignored(row.word))
					counted++;
				// hold off mid-phase until every result is back
				if (!paused && counted == WORDS_PER_PHASE / 2) begin
					paused = 1'b1;
					s_tvalid <= 1'b0;
					do
						@(posedge clk);
					while (pending_results.size() != 0);
				end
			end
		end

		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("PASS sonar_collision_guard_unit");
		else
			$display("FAIL sonar_collision_guard_unit");
		$finish;
	end

endmodule

[files.f]
rtl/scg_pkg.sv
rtl/scg_cfg_regs.sv
rtl/scg_core.sv
rtl/sonar_collision_guard_unit.sv
tb/tb_top.sv
